/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/rna_fold_pkg.sv */
// Package: types, sizes and datapath op codes of the RNA fold block.
`timescale 1ns / 1ps
package rna_fold_pkg;

  localparam int MAX_LEN  = 256;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int IDX_W    = $clog2(MAX_LEN);
  localparam int TRI_SIZE = (MAX_LEN + 1) * (MAX_LEN + 2) / 2;
  localparam int ADDR_W   = $clog2(TRI_SIZE);
  localparam int SCORE_W  = 8;
  localparam int CFG_W    = 4;
  localparam int PROD_W   = 2 * LEN_W + 1;

  localparam logic [1:0] PAIR_SUM = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAX,
    OP_PAIR,
    OP_TMP,
    OP_SUM,
    OP_OUT
  } op_e;

  typedef struct packed {
    logic [1:0] residue;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   seq_length;
    logic               overflow;
  } result_t;

  typedef struct packed {
    op_e              op;
    logic             wr_en;
    logic             wr_zero;
    logic             load;
    logic [LEN_W-1:0] e;
    logic [LEN_W-1:0] l;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0] count;
  } stat_t;

endpackage

/* rtl/rna_max_pair_fold_score_top.sv */
// Top level of the maximum base-pair RNA fold scorer.
`timescale 1ns / 1ps
//
// channel  | ports                        | handshake
// ---------+------------------------------+-----------------------------------
// residue  | start, item_i, busy          | beat when start && !busy
// result   | done_o, result_o             | one-cycle strobe, cannot stall
// config   | cfg_we_i, cfg_wdata_i        | write when cfg_we_i, no wait
//
// Residues load at one beat per cycle while busy is low. A beat with last set
// starts the fold, and busy stays high until the result strobe. The fold time
// for n residues is set by the single-port score table memory (two reads per
// split point, one read or write per cycle).
// Reset clears the control state, the residue count and the overflow flag;
// the table and residue store need no clearing, each cell is written before
// it is read. Results cannot be held off by the receiver.
module rna_max_pair_fold_score_top import rna_fold_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  item_t            item_i,
  output logic             busy,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output result_t          result_o
);

  cmd_t  cmd;
  stat_t stat;

  // sequence the table walk
  rna_fold_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .last_i      (item_i.last),
    .busy        (busy),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // hold residues and scores, compute each cell
  rna_fold_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* rtl/rna_fold_ctrl.sv */
// Controller: walks the triangular table and sequences datapath reads and writes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rna_fold_ctrl import rna_fold_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             last_i,
  output logic             busy,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  stat_t            stat_i,
  output cmd_t             cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CELL  = 4'd1;
  localparam logic [3:0] S_A     = 4'd2;
  localparam logic [3:0] S_B     = 4'd3;
  localparam logic [3:0] S_P     = 4'd4;
  localparam logic [3:0] S_S1    = 4'd5;
  localparam logic [3:0] S_S2    = 4'd6;
  localparam logic [3:0] S_WAIT  = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [LEN_W-1:0] end_q, end_d, len_q, len_d, split_q, split_d;
  logic [CFG_W-1:0] mhl_q;
  logic             pair_ok, has_split;
  logic [3:0]       adv_state;
  logic [LEN_W-1:0] adv_end, adv_len;

  assign busy      = (state_q != S_IDLE);
  assign pair_ok   = (len_q - LEN_W'(2)) >= LEN_W'(mhl_q);
  assign has_split = len_q >= LEN_W'(4);

  // next cell in column order
  always_comb begin
    adv_state = S_CELL;
    adv_end   = end_q;
    adv_len   = len_q + LEN_W'(1);
    if (len_q == end_q) begin
      adv_len = '0;
      if (end_q == stat_i.count) begin
        adv_state = S_OUT;
      end else begin
        adv_end = end_q + LEN_W'(1);
      end
    end
  end

  always_comb begin
    state_d       = state_q;
    end_d         = end_q;
    len_d         = len_q;
    split_d       = split_q;
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    cmd_o.load    = start && !busy;
    unique case (state_q)
      S_IDLE: begin
        if (start && last_i) begin
          state_d = S_CELL;
          end_d   = '0;
          len_d   = '0;
        end
      end
      S_CELL: begin
        if (len_q < LEN_W'(2)) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_zero = 1'b1;
          cmd_o.e       = end_q;
          cmd_o.l       = len_q;
          state_d       = adv_state;
          end_d         = adv_end;
          len_d         = adv_len;
        end else begin
          state_d = S_A;
        end
      end
      S_A: begin
        cmd_o.op = OP_LOAD;
        cmd_o.e  = end_q - LEN_W'(1);
        cmd_o.l  = len_q - LEN_W'(1);
        state_d  = S_B;
      end
      S_B: begin
        cmd_o.op = OP_MAX;
        cmd_o.e  = end_q;
        cmd_o.l  = len_q - LEN_W'(1);
        split_d  = LEN_W'(2);
        priority if (pair_ok)   state_d = S_P;
        else if (has_split)     state_d = S_S1;
        else                    state_d = S_WAIT;
      end
      S_P: begin
        cmd_o.op = OP_PAIR;
        cmd_o.e  = end_q - LEN_W'(1);
        cmd_o.l  = len_q - LEN_W'(2);
        state_d  = has_split ? S_S1 : S_WAIT;
      end
      S_S1: begin
        cmd_o.op = OP_TMP;
        cmd_o.e  = end_q;
        cmd_o.l  = split_q;
        state_d  = S_S2;
      end
      S_S2: begin
        cmd_o.op = OP_SUM;
        cmd_o.e  = end_q - split_q;
        cmd_o.l  = len_q - split_q;
        if (split_q + LEN_W'(2) == len_q) begin
          state_d = S_WAIT;
        end else begin
          split_d = split_q + LEN_W'(1);
          state_d = S_S1;
        end
      end
      S_WAIT: state_d = S_WRITE;
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.e     = end_q;
        cmd_o.l     = len_q;
        state_d     = adv_state;
        end_d       = adv_end;
        len_d       = adv_len;
      end
      S_OUT: begin
        cmd_o.op = OP_OUT;
        cmd_o.e  = stat_i.count;
        cmd_o.l  = stat_i.count;
        state_d  = S_EMIT;
      end
      S_EMIT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      end_q   <= '0;
      len_q   <= '0;
      split_q <= '0;
      mhl_q   <= '0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      len_q   <= len_d;
      split_q <= split_d;
      if (cfg_we_i) begin
        mhl_q <= cfg_wdata_i;
      end
    end
  end

  `ASSERT_CLK(a_last_starts_fold, (start && !busy && last_i) |=> busy, "fold did not start")
  `ASSERT_CLK(a_no_rw_mix, cmd_o.wr_en |-> (cmd_o.op == OP_NONE), "read and write together")

endmodule

/* rtl/rna_fold_dp.sv */
// Datapath: residue store, score table memory, max/add unit and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rna_fold_dp import rna_fold_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  item_t   item_i,
  input  cmd_t    cmd_i,
  output stat_t   stat_o,
  output logic    done_o,
  output result_t result_o
);

  logic [1:0]         res_mem [MAX_LEN];
  logic [SCORE_W-1:0] dp_mem  [TRI_SIZE];

  logic [LEN_W-1:0]   count_q;
  logic               ovf_q;
  op_e                op_q;
  logic [SCORE_W-1:0] rd_q, best_q, best_d, tmp_q;
  logic [1:0]         ra_q, rb_q;
  logic               done_q;
  result_t            result_q;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  addr;
  logic [SCORE_W:0]   cand;
  logic [IDX_W-1:0]   ra_idx;

  assign prod   = {{(LEN_W+1){1'b0}}, cmd_i.e} * {{(LEN_W+1){1'b0}}, cmd_i.e + LEN_W'(1)};
  assign addr   = ADDR_W'(prod[PROD_W-1:1]) + ADDR_W'(cmd_i.l);
  assign ra_idx = IDX_W'(cmd_i.e - cmd_i.l - LEN_W'(1));

  // table port: one access per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      dp_mem[addr] <= cmd_i.wr_zero ? '0 : best_q;
    end
    rd_q <= dp_mem[addr];
    ra_q <= res_mem[ra_idx];
    rb_q <= res_mem[IDX_W'(cmd_i.e)];
    if (cmd_i.load && (count_q < LEN_W'(MAX_LEN))) begin
      res_mem[IDX_W'(count_q)] <= item_i.residue;
    end
  end

  always_comb begin
    cand   = {1'b0, rd_q};
    best_d = best_q;
    unique case (op_q)
      OP_PAIR: cand = {1'b0, rd_q} + ((ra_q + rb_q == PAIR_SUM) ? (SCORE_W+1)'(1) : '0);
      OP_SUM:  cand = {1'b0, rd_q} + {1'b0, tmp_q};
      default: cand = {1'b0, rd_q};
    endcase
    unique case (op_q)
      OP_LOAD:                 best_d = rd_q;
      OP_MAX, OP_PAIR, OP_SUM: if (cand > {1'b0, best_q}) best_d = cand[SCORE_W-1:0];
      default:                 best_d = best_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    if (op_q == OP_TMP) begin
      tmp_q <= rd_q;
    end
    if (op_q == OP_OUT) begin
      result_q.score      <= rd_q;
      result_q.seq_length <= count_q;
      result_q.overflow   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      op_q    <= OP_NONE;
      done_q  <= 1'b0;
    end else begin
      op_q   <= cmd_i.op;
      done_q <= (op_q == OP_OUT);
      if (op_q == OP_OUT) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (cmd_i.load) begin
        if (count_q < LEN_W'(MAX_LEN)) begin
          count_q <= count_q + LEN_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.count = count_q;
  assign done_o       = done_q;
  assign result_o     = result_q;

  `ASSERT_CLK(a_done_follows_out, done_q |-> $past(op_q == OP_OUT), "stray result strobe")

endmodule

/* tb/sv/rna_max_pair_fold_score_top_tb.sv */
// Testbench for the RNA maximum base-pair fold scorer: predicted scores checked beat by beat.
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the sequence being loaded and predicts the fold result.
class fold_scoreboard;
  int unsigned hairpin_min;
  int unsigned stored_count;
  bit          dropped;
  bit [1:0]    bases[rna_fold_pkg::MAX_LEN];
  int unsigned cyk[rna_fold_pkg::MAX_LEN+1][rna_fold_pkg::MAX_LEN+1];
  rna_fold_pkg::result_t expected_folds[$];
  int unsigned errors;
  int unsigned folds_checked;
  int unsigned max_len_seen;

  function new();
    hairpin_min = 0;
    stored_count = 0;
    dropped = 0;
    errors = 0;
    folds_checked = 0;
    max_len_seen = 0;
  endfunction

  // Fill the table over spans ending at each position; cyk[end][len].
  function int unsigned best_pairs(int unsigned n);
    int unsigned best;
    int unsigned cand;
    int unsigned first;
    for (int unsigned e = 0; e <= n; e++) begin
      cyk[e][0] = 0;
      if (e >= 1) cyk[e][1] = 0;
      for (int unsigned l = 2; l <= e; l++) begin
        first = e - l + 1;
        best = cyk[e-1][l-1];
        if (cyk[e][l-1] > best) best = cyk[e][l-1];
        if (l - 2 >= hairpin_min) begin
          cand = cyk[e-1][l-2];
          if (bases[first-1] + bases[e-1] == 3) cand++;
          if (cand > best) best = cand;
        end
        for (int unsigned s = 2; s + 2 <= l; s++) begin
          cand = cyk[e][s] + cyk[e-s][l-s];
          if (cand > best) best = cand;
        end
        cyk[e][l] = best;
      end
    end
    return cyk[n][n];
  endfunction

  // Note an accepted residue beat; a last beat queues one expected result.
  function void note_residue(rna_fold_pkg::item_t it);
    rna_fold_pkg::result_t r;
    int unsigned sc;
    if (stored_count < rna_fold_pkg::MAX_LEN) begin
      bases[stored_count] = it.residue;
      stored_count++;
    end else begin
      dropped = 1;
    end
    if (it.last) begin
      sc = best_pairs(stored_count);
      if (sc > 255) sc = 255;
      r.score = sc[rna_fold_pkg::SCORE_W-1:0];
      r.seq_length = stored_count[rna_fold_pkg::LEN_W-1:0];
      r.overflow = dropped;
      expected_folds.push_back(r);
      if (stored_count > max_len_seen) max_len_seen = stored_count;
      stored_count = 0;
      dropped = 0;
    end
  endfunction

  task report(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, folds_checked);
    errors++;
  endtask

  // Compare a result strobe against the oldest prediction.
  task check_result(rna_fold_pkg::result_t got);
    rna_fold_pkg::result_t want;
    if (expected_folds.size() == 0) begin
      report("unexpected result, score", got.score, 0);
      return;
    end
    want = expected_folds.pop_front();
    if (got.score !== want.score) report("score", got.score, want.score);
    if (got.seq_length !== want.seq_length) report("seq_length", got.seq_length, want.seq_length);
    if (got.overflow !== want.overflow) report("overflow", got.overflow, want.overflow);
    folds_checked++;
  endtask
endclass

module rna_max_pair_fold_score_top_tb;
  import rna_fold_pkg::*;

  // Watchdog limit: must outlast a full 256-residue fold, which has no beat.
  localparam int unsigned IDLE_LIMIT = 30_000_000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  item_t            item_i;
  logic             busy;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             done_o;
  result_t          result_o;

  fold_scoreboard sb;
  int unsigned beats;
  int unsigned residues_sent;
  int unsigned idle_cycles;

  rna_max_pair_fold_score_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Check every result strobe; the receiver never stalls.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(result_o);
      beats++;
    end
  end

  // Count cycles with no beat on either side; give up past the limit.
  int unsigned beats_last;
  always @(posedge clk_i) begin
    if (beats != beats_last) begin
      beats_last <= beats;
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("rna_max_pair_fold_score_top_tb: errors");
        $finish;
      end
    end
  end

  // Send one residue beat after the given gap; hold start until busy is low at an edge.
  task send_residue(logic [1:0] code, logic is_last, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{residue: code, last: is_last};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_residue('{residue: code, last: is_last});
    beats++;
    residues_sent++;
  endtask

  // Drop start and wait out every pending fold, then a short settle.
  task drain();
    @(posedge clk_i);
    start <= 1'b0;
    while (sb.expected_folds.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Write the hairpin register while the block is idle.
  task write_hairpin(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.hairpin_min = v;
    @(posedge clk_i);
  endtask

  // Send a whole sequence; an empty gap stretch now and then.
  task send_sequence(logic [1:0] codes[$], bit no_gaps);
    for (int i = 0; i < codes.size(); i++) begin
      send_residue(codes[i], i == codes.size() - 1, no_gaps ? 0 : $urandom_range(0, 3));
    end
  endtask

  logic [1:0] seq[$];
  int unsigned len;

  initial begin
    sb = new();
    beats = 0;
    beats_last = 0;
    idle_cycles = 0;
    residues_sent = 0;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single residues of every code give score 0.
    for (int c = 0; c < 4; c++) begin
      seq = '{c[1:0]};
      send_sequence(seq, 1);
    end
    // Directed: both pairing combinations with no loop needed, a non-pairing couple and a longer mix.
    seq = '{2'd0, 2'd3};  send_sequence(seq, 1);
    seq = '{2'd2, 2'd1};  send_sequence(seq, 0);
    seq = '{2'd2, 2'd3};  send_sequence(seq, 0);
    seq = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd3, 2'd0}; send_sequence(seq, 0);

    // Directed: widest loop, AU pair enclosing exactly 15, then short pairs the loop forbids.
    write_hairpin(15);
    seq = '{2'd0};
    repeat (15) seq.push_back(2'd2);
    seq.push_back(2'd3);
    send_sequence(seq, 0);
    seq = '{2'd0, 2'd3, 2'd1, 2'd2};
    send_sequence(seq, 1);

    // Random phase: short sequences mostly, a few longer, hairpin changed now and then between sequences.
    write_hairpin(0);
    while (residues_sent < 1550 - 257) begin
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 3))
          0: write_hairpin(0);
          1: write_hairpin(15);
          default: write_hairpin($urandom_range(0, 4));
        endcase
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      seq = {};
      for (int i = 0; i < len; i++) seq.push_back(2'($urandom_range(0, 3)));
      send_sequence(seq, $urandom_range(0, 4) == 0);
    end

    // Full store: alternating AU over 258 beats, the last two dropped, score 128.
    write_hairpin(0);
    seq = {};
    for (int i = 0; i < 258; i++) seq.push_back((i % 2) ? 2'd3 : 2'd0);
    send_sequence(seq, 1);

    drain();
    repeat (20) @(posedge clk_i);
    $display("covered %0d residues in %0d folds, longest %0d, hairpin 0..15 and overflow",
             residues_sent, sb.folds_checked, sb.max_len_seen);
    if (sb.errors == 0 && sb.expected_folds.size() == 0) begin
      $display("rna_max_pair_fold_score_top_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expected_folds.size());
      $display("rna_max_pair_fold_score_top_tb: errors");
    end
    $finish;
  end
endmodule
